// ===== hdl/ffha_pkg.sv =====
`default_nettype none
package ffha_pkg;

    localparam int FREE_SEGMENTS = 64;
    localparam int USED_BLOCKS   = 64;
    localparam int FS_IDX_W      = $clog2(FREE_SEGMENTS);
    localparam int FS_CNT_W      = $clog2(FREE_SEGMENTS + 1);
    localparam int UB_IDX_W      = $clog2(USED_BLOCKS);

    localparam logic [31:0] MIN_BLOCK = 32'd32;
    localparam logic [31:0] HDR       = 32'd8;

    localparam logic [1:0] ACT_INIT   = 2'd0;
    localparam logic [1:0] ACT_ALLOC  = 2'd1;
    localparam logic [1:0] ACT_FREE   = 2'd2;
    localparam logic [1:0] ACT_RESIZE = 2'd3;

    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_NO_MEMORY  = 2'd1;
    localparam logic [1:0] ST_UNKNOWN    = 2'd2;
    localparam logic [1:0] ST_TABLE_FULL = 2'd3;

    localparam logic REG_HEAP_START = 1'b0;
    localparam logic REG_HEAP_END   = 1'b1;

    typedef struct packed {
        logic [1:0]  action;
        logic [31:0] pointer;
        logic [31:0] request_size;
    } cmd_t;

    typedef struct packed {
        logic [31:0] address;
        logic [1:0]  status;
        logic        moved;
        logic [31:0] copy_length;
    } result_t;

    typedef struct packed {
        logic [31:0] addr;
        logic [31:0] size;
    } seg_t;

    typedef enum logic [1:0] {
        OP_ALLOC,
        OP_FREE,
        OP_RESIZE
    } op_t;

    typedef enum logic [1:0] {
        RET_AC,
        RET_FC,
        RET_FIN
    } ret_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_UFREE,
        S_FU_RD,
        S_FU_CHK,
        S_AC_RD,
        S_AC_CHK,
        S_AC_DONE,
        S_FC_RD,
        S_FC_CHK,
        S_FC_DEC,
        S_FC_DONE,
        S_RS_RD,
        S_RS_CHK,
        S_RM_RD,
        S_RM_WR,
        S_IN_RD,
        S_IN_WR,
        S_FINISH
    } state_t;

endpackage
`default_nettype wire

// ===== hdl/ffha_ram.sv =====
`default_nettype none
module ffha_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

// ===== hdl/first_fit_heap_allocator_top.sv =====
`default_nettype none
// First-fit heap allocator with an address-sorted free table and coalescing.
// A command (init, allocate, free, resize) is taken when start is high and
// busy is low. Exactly one result follows: done is high for one cycle and
// the result ports hold the payload during that cycle; the receiver cannot
// hold it off, so it must take the transfer then.
// The free segments sit in one synchronous memory and the allocated blocks
// in another, each with a registered read port; valid bits of the used
// table are flip-flops. A command walks the tables entry by entry: it scans
// used entries for a free slot, searches used entries for a pointer, visits
// free entries, and moves entries when a segment is removed or inserted.
// Only one command is in flight at a time. The user writes heap_start and
// heap_end through the cfg port only while idle; the block does not enforce it.
// Reset empties the heap and the used table; an init is needed before use.
module first_fit_heap_allocator_top (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  var  ffha_pkg::cmd_t    cmd,
    output logic                   busy,
    output logic                   done,
    output ffha_pkg::result_t      result,
    input  wire logic              cfg_we,
    input  wire logic              cfg_index,
    input  wire logic [31:0]       cfg_data
);
    import ffha_pkg::*;

    state_t state_reg, state_next;
    op_t    op_reg, op_next;
    ret_t   ret_reg, ret_next;

    logic [31:0] heap_start_reg, heap_end_reg;
    logic [31:0] ptr_reg, ptr_next;
    logic [31:0] s_reg, s_next;
    logic [31:0] old_reg, old_next;
    logic [31:0] body_reg, body_next;
    logic [31:0] bs_reg, bs_next;
    logic [FS_CNT_W-1:0] cnt_reg, cnt_next;
    logic [FS_CNT_W-1:0] i_reg, i_next;
    logic [FS_CNT_W-1:0] j_reg, j_next;
    logic [UB_IDX_W-1:0] k_reg, k_next;
    logic [USED_BLOCKS-1:0] valid_reg, valid_next;
    seg_t prev_reg, prev_next;
    seg_t cur_reg, cur_next;
    logic cur_hit_reg, cur_hit_next;
    seg_t ac_seg_reg, ac_seg_next;
    logic [FS_IDX_W-1:0] ac_idx_reg, ac_idx_next;
    logic ac_split_reg, ac_split_next;
    result_t res_reg, res_next;

    logic                fm_we;
    logic [FS_IDX_W-1:0] fm_waddr, fm_raddr;
    seg_t                fm_wdata, fm_rdata;
    logic                um_we;
    logic [UB_IDX_W-1:0] um_waddr;
    seg_t                um_wdata, um_rdata;

    ffha_ram #(.WIDTH($bits(seg_t)), .DEPTH(FREE_SEGMENTS)) u_free_ram (
        .clk   (clk),
        .we    (fm_we),
        .waddr (fm_waddr),
        .wdata (fm_wdata),
        .raddr (fm_raddr),
        .rdata (fm_rdata)
    );

    ffha_ram #(.WIDTH($bits(seg_t)), .DEPTH(USED_BLOCKS)) u_used_ram (
        .clk   (clk),
        .we    (um_we),
        .waddr (um_waddr),
        .wdata (um_wdata),
        .raddr (k_reg),
        .rdata (um_rdata)
    );

    // Shared decisions
    logic        accept, init_ok, k_last, i_in, cnt_full;
    logic        ac_fit, ac_split_c, nm, pm, rs_hit, rs_fit, rs_split;
    logic [31:0] s_raised, hdr, ac_rem;
    logic [32:0] blk_end;
    logic [33:0] prev_end, avail, avail_rem;

    assign accept     = start && (state_reg == S_IDLE);
    assign init_ok    = (heap_end_reg >= heap_start_reg)
                        && ((heap_end_reg - heap_start_reg) >= HDR);
    assign s_raised   = (cmd.request_size < MIN_BLOCK) ? MIN_BLOCK : cmd.request_size;
    assign k_last     = (k_reg == UB_IDX_W'(USED_BLOCKS - 1));
    assign i_in       = (i_reg < cnt_reg);
    assign cnt_full   = (cnt_reg >= FS_CNT_W'(FREE_SEGMENTS));
    assign hdr        = ptr_reg - HDR;
    assign blk_end    = {1'b0, ptr_reg} + {1'b0, old_reg};
    assign ac_fit     = (fm_rdata.size >= s_reg);
    assign ac_rem     = fm_rdata.size - s_reg;
    assign ac_split_c = (ac_rem >= MIN_BLOCK);
    assign nm         = cur_hit_reg && ({1'b0, cur_reg.addr} == blk_end);
    assign prev_end   = {2'b0, prev_reg.addr} + {2'b0, HDR} + {2'b0, prev_reg.size};
    assign pm         = (i_reg != '0) && (prev_end == {2'b0, hdr});
    assign rs_hit     = ({1'b0, fm_rdata.addr} == blk_end);
    assign avail      = {2'b0, old_reg} + {2'b0, HDR} + {2'b0, fm_rdata.size};
    assign rs_fit     = (avail >= {2'b0, s_reg});
    assign avail_rem  = avail - {2'b0, s_reg};
    assign rs_split   = (avail_rem >= {2'b0, MIN_BLOCK});

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    case (cmd.action)
                        ACT_INIT:  state_next = S_FINISH;
                        ACT_ALLOC: state_next = (cmd.request_size == '0) ? S_FINISH : S_UFREE;
                        ACT_FREE:  state_next = (cmd.pointer == '0) ? S_FINISH : S_FU_RD;
                        default:
                        begin
                            if (cmd.pointer != '0)
                            begin
                                state_next = S_FU_RD;
                            end
                            else
                            begin
                                state_next = (cmd.request_size == '0) ? S_FINISH : S_UFREE;
                            end
                        end
                    endcase
                end
            end
            S_UFREE:
            begin
                if (!valid_reg[k_reg])
                begin
                    state_next = S_AC_RD;
                end
                else if (k_last)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FU_RD:  state_next = S_FU_CHK;
            S_FU_CHK:
            begin
                if (valid_reg[k_reg] && um_rdata.addr == ptr_reg)
                begin
                    state_next = (op_reg == OP_FREE) ? S_FC_RD : S_RS_RD;
                end
                else
                begin
                    state_next = k_last ? S_FINISH : S_FU_RD;
                end
            end
            S_AC_RD:  state_next = i_in ? S_AC_CHK : S_FINISH;
            S_AC_CHK:
            begin
                if (!ac_fit)
                begin
                    state_next = S_AC_RD;
                end
                else
                begin
                    state_next = ac_split_c ? S_AC_DONE : S_RM_RD;
                end
            end
            S_AC_DONE: state_next = (op_reg == OP_ALLOC) ? S_FINISH : S_FC_RD;
            S_FC_RD:   state_next = i_in ? S_FC_CHK : S_FC_DEC;
            S_FC_CHK:  state_next = (fm_rdata.addr < hdr) ? S_FC_RD : S_FC_DEC;
            S_FC_DEC:
            begin
                if (pm && nm)
                begin
                    state_next = S_RM_RD;
                end
                else if (pm || nm)
                begin
                    state_next = S_FC_DONE;
                end
                else
                begin
                    state_next = cnt_full ? S_FINISH : S_IN_RD;
                end
            end
            S_FC_DONE: state_next = S_FINISH;
            S_RS_RD:   state_next = i_in ? S_RS_CHK : S_AC_RD;
            S_RS_CHK:
            begin
                if (rs_hit)
                begin
                    if (!rs_fit)
                    begin
                        state_next = S_AC_RD;
                    end
                    else
                    begin
                        state_next = rs_split ? S_FINISH : S_RM_RD;
                    end
                end
                else
                begin
                    state_next = S_RS_RD;
                end
            end
            S_RM_RD:
            begin
                if ((j_reg + 1'b1) >= cnt_reg)
                begin
                    case (ret_reg)
                        RET_AC:  state_next = S_AC_DONE;
                        RET_FC:  state_next = S_FC_DONE;
                        default: state_next = S_FINISH;
                    endcase
                end
                else
                begin
                    state_next = S_RM_WR;
                end
            end
            S_RM_WR:  state_next = S_RM_RD;
            S_IN_RD:  state_next = (j_reg > i_reg) ? S_IN_WR : S_FC_DONE;
            S_IN_WR:  state_next = S_IN_RD;
            S_FINISH: state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        op_next       = op_reg;
        ret_next      = ret_reg;
        ptr_next      = ptr_reg;
        s_next        = s_reg;
        old_next      = old_reg;
        body_next     = body_reg;
        bs_next       = bs_reg;
        cnt_next      = cnt_reg;
        i_next        = i_reg;
        j_next        = j_reg;
        k_next        = k_reg;
        valid_next    = valid_reg;
        prev_next     = prev_reg;
        cur_next      = cur_reg;
        cur_hit_next  = cur_hit_reg;
        ac_seg_next   = ac_seg_reg;
        ac_idx_next   = ac_idx_reg;
        ac_split_next = ac_split_reg;
        res_next      = res_reg;
        fm_we         = 1'b0;
        fm_waddr      = i_reg[FS_IDX_W-1:0];
        fm_wdata      = fm_rdata;
        fm_raddr      = i_reg[FS_IDX_W-1:0];
        um_we         = 1'b0;
        um_waddr      = k_reg;
        um_wdata      = '{addr: body_reg, size: bs_reg};
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    res_next = '0;
                    ptr_next = cmd.pointer;
                    s_next   = s_raised;
                    i_next   = '0;
                    k_next   = '0;
                    op_next  = OP_ALLOC;
                    if (cmd.action == ACT_FREE)
                    begin
                        op_next = OP_FREE;
                    end
                    else if (cmd.action == ACT_RESIZE && cmd.pointer != '0)
                    begin
                        op_next = OP_RESIZE;
                    end
                    if (cmd.action == ACT_INIT)
                    begin
                        valid_next = '0;
                        if (init_ok)
                        begin
                            fm_we    = 1'b1;
                            fm_waddr = '0;
                            fm_wdata = '{addr: heap_start_reg,
                                         size: heap_end_reg - heap_start_reg - HDR};
                            cnt_next = FS_CNT_W'(1);
                        end
                        else
                        begin
                            cnt_next        = '0;
                            res_next.status = ST_NO_MEMORY;
                        end
                    end
                end
            end
            S_UFREE:
            begin
                if (valid_reg[k_reg])
                begin
                    if (k_last)
                    begin
                        res_next.status = ST_TABLE_FULL;
                    end
                    else
                    begin
                        k_next = k_reg + 1'b1;
                    end
                end
            end
            S_FU_CHK:
            begin
                if (valid_reg[k_reg] && um_rdata.addr == ptr_reg)
                begin
                    old_next     = um_rdata.size;
                    i_next       = '0;
                    cur_hit_next = 1'b0;
                end
                else if (k_last)
                begin
                    res_next.status = ST_UNKNOWN;
                end
                else
                begin
                    k_next = k_reg + 1'b1;
                end
            end
            S_AC_RD:
            begin
                if (!i_in)
                begin
                    res_next.status = ST_NO_MEMORY;
                end
            end
            S_AC_CHK:
            begin
                if (ac_fit)
                begin
                    body_next     = fm_rdata.addr + HDR;
                    ac_seg_next   = fm_rdata;
                    ac_idx_next   = i_reg[FS_IDX_W-1:0];
                    ac_split_next = ac_split_c;
                    if (ac_split_c)
                    begin
                        fm_we    = 1'b1;
                        fm_wdata = '{addr: fm_rdata.addr + HDR + s_reg,
                                     size: ac_rem - HDR};
                        bs_next  = s_reg;
                    end
                    else
                    begin
                        bs_next  = fm_rdata.size;
                        j_next   = i_reg;
                        ret_next = RET_AC;
                    end
                end
                else
                begin
                    i_next = i_reg + 1'b1;
                end
            end
            S_AC_DONE:
            begin
                if (op_reg == OP_ALLOC)
                begin
                    um_we              = 1'b1;
                    valid_next[k_reg]  = 1'b1;
                    res_next.address   = body_reg;
                end
                else
                begin
                    i_next       = '0;
                    cur_hit_next = 1'b0;
                end
            end
            S_FC_CHK:
            begin
                if (fm_rdata.addr < hdr)
                begin
                    prev_next = fm_rdata;
                    i_next    = i_reg + 1'b1;
                end
                else
                begin
                    cur_next     = fm_rdata;
                    cur_hit_next = 1'b1;
                end
            end
            S_FC_DEC:
            begin
                if (pm)
                begin
                    fm_we    = 1'b1;
                    fm_waddr = FS_IDX_W'(i_reg - 1'b1);
                    if (nm)
                    begin
                        fm_wdata = '{addr: prev_reg.addr,
                                     size: prev_reg.size + HDR + old_reg + HDR + cur_reg.size};
                        j_next   = i_reg;
                        ret_next = RET_FC;
                    end
                    else
                    begin
                        fm_wdata = '{addr: prev_reg.addr, size: prev_reg.size + HDR + old_reg};
                    end
                end
                else if (nm)
                begin
                    fm_we    = 1'b1;
                    fm_wdata = '{addr: hdr, size: old_reg + HDR + cur_reg.size};
                end
                else if (cnt_full)
                begin
                    res_next.status = ST_TABLE_FULL;
                    // A moving resize undoes the split made by its allocation.
                    if (op_reg == OP_RESIZE && ac_split_reg)
                    begin
                        fm_we    = 1'b1;
                        fm_waddr = ac_idx_reg;
                        fm_wdata = ac_seg_reg;
                    end
                end
                else
                begin
                    j_next = cnt_reg;
                end
            end
            S_FC_DONE:
            begin
                if (op_reg == OP_FREE)
                begin
                    valid_next[k_reg] = 1'b0;
                end
                else
                begin
                    um_we                = 1'b1;
                    res_next.address     = body_reg;
                    res_next.moved       = 1'b1;
                    res_next.copy_length = (old_reg < bs_reg) ? old_reg : bs_reg;
                end
            end
            S_RS_RD:
            begin
                if (!i_in)
                begin
                    i_next = '0;
                end
            end
            S_RS_CHK:
            begin
                if (rs_hit)
                begin
                    if (rs_fit)
                    begin
                        um_we            = 1'b1;
                        res_next.address = ptr_reg;
                        if (rs_split)
                        begin
                            fm_we    = 1'b1;
                            fm_wdata = '{addr: ptr_reg + s_reg,
                                         size: avail_rem[31:0] - HDR};
                            um_wdata = '{addr: ptr_reg, size: s_reg};
                        end
                        else
                        begin
                            um_wdata = '{addr: ptr_reg, size: avail[31:0]};
                            j_next   = i_reg;
                            ret_next = RET_FIN;
                        end
                    end
                    else
                    begin
                        i_next = '0;
                    end
                end
                else
                begin
                    i_next = i_reg + 1'b1;
                end
            end
            S_RM_RD:
            begin
                fm_raddr = FS_IDX_W'(j_reg + 1'b1);
                if ((j_reg + 1'b1) >= cnt_reg)
                begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            S_RM_WR:
            begin
                fm_we    = 1'b1;
                fm_waddr = j_reg[FS_IDX_W-1:0];
                j_next   = j_reg + 1'b1;
            end
            S_IN_RD:
            begin
                fm_raddr = FS_IDX_W'(j_reg - 1'b1);
                if (j_reg <= i_reg)
                begin
                    fm_we    = 1'b1;
                    fm_wdata = '{addr: hdr, size: old_reg};
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_IN_WR:
            begin
                fm_we    = 1'b1;
                fm_waddr = j_reg[FS_IDX_W-1:0];
                j_next   = j_reg - 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            cnt_reg        <= '0;
            valid_reg      <= '0;
            heap_start_reg <= '0;
            heap_end_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            valid_reg <= valid_next;
            if (cfg_we && cfg_index == REG_HEAP_START)
            begin
                heap_start_reg <= cfg_data;
            end
            if (cfg_we && cfg_index == REG_HEAP_END)
            begin
                heap_end_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        ret_reg      <= ret_next;
        ptr_reg      <= ptr_next;
        s_reg        <= s_next;
        old_reg      <= old_next;
        body_reg     <= body_next;
        bs_reg       <= bs_next;
        i_reg        <= i_next;
        j_reg        <= j_next;
        k_reg        <= k_next;
        prev_reg     <= prev_next;
        cur_reg      <= cur_next;
        cur_hit_reg  <= cur_hit_next;
        ac_seg_reg   <= ac_seg_next;
        ac_idx_reg   <= ac_idx_next;
        ac_split_reg <= ac_split_next;
        res_reg      <= res_next;
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = (state_reg == S_FINISH);
    assign result = res_reg;

endmodule
`default_nettype wire
